>>> design/uule_pkg.sv
// ----------------------------------------------------------------------------
// uule_pkg
// Shared types, constants and the character mapping for the uuencode line
// encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

  // Default number of raw bytes in one encoded line.
  localparam int DEF_LINE_BYTES = 45;

  // Width of byte counts and byte indexes within a line.
  localparam int CNT_W = 6;

  // Fixed output characters.
  localparam logic [6:0] NEWLINE_CHAR = 7'd10;
  localparam logic [6:0] ZERO_CHAR    = 7'd96;

  // Input command codes.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [6:0] char_out;
    logic       run_last;
  } out_item_t;

  // A line job handed from the front end to the back end.
  typedef struct packed {
    logic             bank;
    logic             is_end;
    logic [CNT_W-1:0] count;
  } job_t;

  // Line buffer write request from the front end.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  // Map a 6-bit value to its printable character.
  function automatic logic [6:0] uu_char(input logic [5:0] v);
    logic [6:0] c;
    if (v == 6'd0) begin
      c = ZERO_CHAR;
    end else begin
      c = {1'b0, v} + 7'd32;
    end
    return c;
  endfunction

endpackage

>>> design/uuencode_line_encoder.sv
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Encodes raw bytes into uuencode body lines, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue: a transaction is taken when push is high and full
// is low. cmd selects a data byte or end of input. The result side is also a
// queue: while empty is low, out_item holds the oldest character, taken when
// pop is high. run_last marks the last character caused by one input.
// The front end takes one byte a cycle, while full is low, into one of two line
// banks; full rises only while both banks hold lines not yet fully encoded.
// The back end sends one character a cycle while the receiver takes them, but
// none during the byte fetch or while picking up a job. The first character of
// a run reaches the outputs once the job is queued, picked up by the back end
// and the length character is loaded into the output register; a byte fetch
// follows before the first group. Sustained input is set by the byte fetch and
// the single output character per cycle.
// A stalled receiver halts the back end in place; the front end keeps filling
// the free bank. Reset empties the job queue and the fill count; the buffer
// memory is not cleared.
// ----------------------------------------------------------------------------
module uuencode_line_encoder #(
  parameter int LINE_BYTES = uule_pkg::DEF_LINE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  uule_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output uule_pkg::out_item_t out_item
);
  import uule_pkg::*;

  logic q_full;
  logic job_push;
  logic job_pop;
  logic job_valid;
  job_t job_in;
  job_t job_head;
  wr_t  wr;

  // Front end: accepts and classifies input transactions.
  uule_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job_in),
    .wr       (wr)
  );

  // Line jobs waiting for the back end.
  uule_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_push  (job_push),
    .job_in    (job_in),
    .job_pop   (job_pop),
    .job_valid (job_valid),
    .q_full    (q_full),
    .job_head  (job_head)
  );

  // Back end: line buffer and character sequencer.
  uule_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .job_valid (job_valid),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

>>> design/uule_front.sv
// ----------------------------------------------------------------------------
// uule_front
// Accepts input transactions, stores data bytes into the current line bank and
// posts a line job when the line fills or the input ends.
// ----------------------------------------------------------------------------
module uule_front #(
  parameter int LINE_BYTES = uule_pkg::DEF_LINE_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  uule_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              job_push,
  output uule_pkg::job_t    job,
  output uule_pkg::wr_t     wr
);
  import uule_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic [CNT_W-1:0] count_inc;

  // Both line banks are busy when the job queue is full.
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign count_inc = count_r + CNT_W'(1);

  // Classify the transaction and decide on a job.
  always_comb begin
    count_nxt = count_r;
    bank_nxt  = bank_r;
    job_push  = 1'b0;
    job       = '0;
    wr.en     = accept && (in_item.cmd == CMD_DATA);
    wr.bank   = bank_r;
    wr.idx    = count_r;
    wr.data   = in_item.data_byte;
    if (accept) begin
      if (in_item.cmd == CMD_DATA) begin
        if (count_inc == CNT_W'(LINE_BYTES)) begin
          job_push  = 1'b1;
          job.bank  = bank_r;
          job.count = count_inc;
          count_nxt = '0;
          bank_nxt  = !bank_r;
        end else begin
          count_nxt = count_inc;
        end
      end else begin
        job_push   = 1'b1;
        job.bank   = bank_r;
        job.is_end = 1'b1;
        job.count  = count_r;
        count_nxt  = '0;
        bank_nxt   = !bank_r;
      end
    end
  end

  // Fill count and bank select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

>>> design/uule_jobq.sv
// ----------------------------------------------------------------------------
// uule_jobq
// Two-entry queue of line jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module uule_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_push,
  input  uule_pkg::job_t job_in,
  input  logic           job_pop,
  output logic           job_valid,
  output logic           q_full,
  output uule_pkg::job_t job_head
);
  import uule_pkg::*;

  job_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign job_valid = (cnt_r != 2'd0);
  assign q_full    = (cnt_r == 2'd2);
  assign job_head  = q_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (job_push) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (job_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (job_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, job_push} - {1'b0, job_pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !job_push || job_pop)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("job popped from an empty queue");
`endif

endmodule

>>> design/uule_back.sv
// ----------------------------------------------------------------------------
// uule_back
// Holds the two-bank line buffer and turns each line job into characters
// through a one-entry output register, one per cycle barring fetch and stalls.
// ----------------------------------------------------------------------------
module uule_back #(
  parameter int LINE_BYTES = uule_pkg::DEF_LINE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  uule_pkg::wr_t       wr,
  input  logic                job_valid,
  input  uule_pkg::job_t      job_head,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output uule_pkg::out_item_t out_item
);
  import uule_pkg::*;

  localparam int DEPTH = 2 * LINE_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_RD, S_EMIT, S_NL, S_ZERO, S_NL2
  } state_t;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data_r;
  logic             pad_r;

  state_t           state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [2:0][7:0]  g_r, g_nxt;
  logic [1:0][7:0]  n_r, n_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             slot_free;
  logic             emit;
  out_item_t        emit_item;
  logic             rd_issue;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pad;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [7:0]       cap_byte;
  logic [CNT_W-1:0] base_next_grp;

  assign slot_free     = !out_valid_r || pop;
  assign empty         = !out_valid_r;
  assign out_item      = out_item_r;
  assign cap_byte      = pad_r ? 8'd0 : rd_data_r;
  assign base_next_grp = base_r + CNT_W'(3);

  // Bytes at or past the line length read as zero padding.
  assign rd_pad  = (rd_idx >= job_r.count);
  assign rd_addr = (job_r.bank ? AW'(LINE_BYTES) : AW'(0)) + AW'(rd_idx);
  assign wr_addr = (wr.bank ? AW'(LINE_BYTES) : AW'(0)) + AW'(wr.idx);

  // Line buffer memory with registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_issue && !rd_pad) begin
      rd_data_r <= mem[rd_addr];
    end
    if (rd_issue) begin
      pad_r <= rd_pad;
    end
  end

  // Sequencer: length character, byte fetch, groups, newline, end line.
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    base_nxt      = base_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    n_nxt         = n_r;
    emit          = 1'b0;
    emit_item     = '0;
    rd_issue      = 1'b0;
    rd_idx        = base_r;
    job_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_nxt   = job_head;
          base_nxt  = '0;
          state_nxt = (job_head.count == '0) ? S_ZERO : S_LEN;
        end
      end
      S_LEN: begin
        emit               = 1'b1;
        emit_item.char_out = uu_char(6'(job_r.count));
        if (slot_free) begin
          k_nxt     = 2'd0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // Issue three reads and collect each on the following cycle.
        rd_issue = (k_r != 2'd3);
        rd_idx   = base_r + CNT_W'(k_r);
        if (k_r != 2'd0) begin
          g_nxt[k_r - 2'd1] = cap_byte;
        end
        if (k_r == 2'd3) begin
          k_nxt     = 2'd0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_EMIT: begin
        emit = 1'b1;
        case (k_r)
          2'd0:    emit_item.char_out = uu_char(g_r[0][7:2]);
          2'd1:    emit_item.char_out = uu_char({g_r[0][1:0], g_r[1][7:4]});
          2'd2:    emit_item.char_out = uu_char({g_r[1][3:0], g_r[2][7:6]});
          default: emit_item.char_out = uu_char(g_r[2][5:0]);
        endcase
        if (slot_free) begin
          // Prefetch the next group while this one is sent.
          rd_issue = (k_r != 2'd3);
          rd_idx   = base_next_grp + CNT_W'(k_r);
          if (k_r == 2'd1 || k_r == 2'd2) begin
            n_nxt[k_r[1]] = cap_byte;
          end
          if (k_r == 2'd3) begin
            k_nxt = 2'd0;
            if (base_next_grp < job_r.count) begin
              base_nxt = base_next_grp;
              g_nxt    = {cap_byte, n_r[1], n_r[0]};
            end else begin
              state_nxt = S_NL;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_NL: begin
        emit               = 1'b1;
        emit_item.char_out = NEWLINE_CHAR;
        emit_item.run_last = !job_r.is_end;
        if (slot_free) begin
          if (job_r.is_end) begin
            state_nxt = S_ZERO;
          end else begin
            job_pop   = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_ZERO: begin
        emit               = 1'b1;
        emit_item.char_out = ZERO_CHAR;
        if (slot_free) begin
          state_nxt = S_NL2;
        end
      end
      S_NL2: begin
        emit               = 1'b1;
        emit_item.char_out = NEWLINE_CHAR;
        emit_item.run_last = 1'b1;
        if (slot_free) begin
          job_pop   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded when a character is ready and the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit && slot_free) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
      job_r       <= job_nxt;
      base_r      <= base_nxt;
      k_r         <= k_nxt;
      g_r         <= g_nxt;
      n_r         <= n_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_after_newline: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == S_NL || state_r == S_NL2))
    else $error("line job released before its newline");
  a_group_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (job_r.count != '0) && (base_r < job_r.count))
    else $error("group start outside the line");
  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.run_last) |-> (out_item_r.char_out == NEWLINE_CHAR))
    else $error("run ends on a character other than newline");
`endif

endmodule
